@@ rtl/mph_pkg.sv @@
`timescale 1ns / 1ps

package mph_pkg;

  // line height coefficients, wavelength spacings in nm
  localparam int SIPF_A  = 62;
  localparam int SIPF_B  = 45;
  localparam int SICF_A  = 45;
  localparam int SICF_B  = 17;
  localparam int BASE_SPAN = 221;
  localparam int SPAN_681  = 17;
  localparam int SPAN_709  = 45;
  localparam int SPAN_753  = 89;
  localparam int BAIR_B    = 45;
  // ndvi >= 0.2 tested as 5*num against den
  localparam int NDVI_SCALE = 5;

  // register reset values, Q2.14
  localparam logic signed [15:0] FLOAT_MPH_THRESHOLD_RST = 16'sd1258;
  localparam logic signed [15:0] BAIR_MINIMUM_RST        = 16'sd33;
  localparam logic signed [15:0] FLOAT_MPH_MINIMUM_RST   = 16'sd328;

  // register indexes
  typedef enum logic [1:0] {
    REG_FLOAT_MPH_THRESHOLD = 2'd0,
    REG_BAIR_MINIMUM        = 2'd1,
    REG_FLOAT_MPH_MINIMUM   = 2'd2,
    REG_UNUSED              = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    PEAK_681 = 2'd0,
    PEAK_709 = 2'd1,
    PEAK_753 = 2'd2
  } peak_t;

  typedef struct packed {
    logic  bad;
    peak_t peak;
  } pix_ctl_t;

  typedef struct packed {
    logic bad_input;
    logic cyano;
    logic floating;
    logic adjacency;
  } flags_t;

  typedef struct packed {
    logic signed [15:0] float_mph_threshold;
    logic signed [15:0] bair_minimum;
    logic signed [15:0] float_mph_minimum;
  } cfg_regs_t;

endpackage

@@ rtl/mph_if.sv @@
`timescale 1ns / 1ps

// pixel input channel
interface mph_in_if #(parameter int REFL_WIDTH = 16) ();
  logic                         valid;
  logic                         ready;
  logic signed [REFL_WIDTH-1:0] refl_620;
  logic signed [REFL_WIDTH-1:0] refl_664;
  logic signed [REFL_WIDTH-1:0] refl_681;
  logic signed [REFL_WIDTH-1:0] refl_709;
  logic signed [REFL_WIDTH-1:0] refl_753;
  logic signed [REFL_WIDTH-1:0] refl_885;
  logic                         is_land;
  logic                         nav_failed;

  modport source (
    output valid, refl_620, refl_664, refl_681, refl_709, refl_753, refl_885,
           is_land, nav_failed,
    input  ready
  );
  modport sink (
    input  valid, refl_620, refl_664, refl_681, refl_709, refl_753, refl_885,
           is_land, nav_failed,
    output ready
  );
endinterface

// flag result channel
interface mph_out_if ();
  logic valid;
  logic ready;
  logic bad_input;
  logic cyano;
  logic floating;
  logic adjacency;

  modport source (
    output valid, bad_input, cyano, floating, adjacency,
    input  ready
  );
  modport sink (
    input  valid, bad_input, cyano, floating, adjacency,
    output ready
  );
endinterface

@@ rtl/mph_prep.sv @@
`timescale 1ns / 1ps

// stage 1: validity check, peak search, band differences and the 885/664 sum
module mph_prep #(
  parameter int REFL_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  logic signed [REFL_WIDTH-1:0] r620,
  input  logic signed [REFL_WIDTH-1:0] r664,
  input  logic signed [REFL_WIDTH-1:0] r681,
  input  logic signed [REFL_WIDTH-1:0] r709,
  input  logic signed [REFL_WIDTH-1:0] r753,
  input  logic signed [REFL_WIDTH-1:0] r885,
  input  logic                         is_land,
  input  logic                         nav_failed,
  output logic                         dn_valid,
  input  logic                         dn_ready,
  output mph_pkg::pix_ctl_t            ctl,
  output logic signed [REFL_WIDTH:0]   d_664_620,
  output logic signed [REFL_WIDTH:0]   d_681_620,
  output logic signed [REFL_WIDTH:0]   d_681_664,
  output logic signed [REFL_WIDTH:0]   d_709_664,
  output logic signed [REFL_WIDTH:0]   d_885_664,
  output logic signed [REFL_WIDTH:0]   d_peak_664,
  output logic signed [REFL_WIDTH:0]   s_885_664
);

  localparam int DW = REFL_WIDTH + 1;

  logic                         valid_r;
  mph_pkg::pix_ctl_t            ctl_r, ctl_nxt;
  logic signed [REFL_WIDTH-1:0] peak_refl;
  logic signed [REFL_WIDTH-1:0] peak0_refl;
  logic                         peak0_681;
  logic signed [DW-1:0]         d0_r, d1_r, d2_r, d3_r, d4_r, d5_r, s0_r;

  assign up_ready = !valid_r || dn_ready;

  // peak search, ties go to the longer wavelength
  always_comb begin
    peak0_681  = r681 > r709;
    peak0_refl = peak0_681 ? r681 : r709;
    if (peak0_refl > r753) begin
      peak_refl    = peak0_refl;
      ctl_nxt.peak = peak0_681 ? mph_pkg::PEAK_681 : mph_pkg::PEAK_709;
    end else begin
      peak_refl    = r753;
      ctl_nxt.peak = mph_pkg::PEAK_753;
    end
    ctl_nxt.bad = (r620 <= 0) || (r664 <= 0) || (r681 <= 0) || (r709 <= 0) ||
                  is_land || nav_failed;
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      ctl_r <= ctl_nxt;
      d0_r  <= DW'(r664) - DW'(r620);
      d1_r  <= DW'(r681) - DW'(r620);
      d2_r  <= DW'(r681) - DW'(r664);
      d3_r  <= DW'(r709) - DW'(r664);
      d4_r  <= DW'(r885) - DW'(r664);
      d5_r  <= DW'(peak_refl) - DW'(r664);
      s0_r  <= DW'(r885) + DW'(r664);
    end
  end

  assign dn_valid   = valid_r;
  assign ctl        = ctl_r;
  assign d_664_620  = d0_r;
  assign d_681_620  = d1_r;
  assign d_681_664  = d2_r;
  assign d_709_664  = d3_r;
  assign d_885_664  = d4_r;
  assign d_peak_664 = d5_r;
  assign s_885_664  = s0_r;

endmodule

@@ rtl/mph_lines.sv @@
`timescale 1ns / 1ps

// stage 2: line heights and ndvi terms by constant multiplication
module mph_lines #(
  parameter int REFL_WIDTH = 16,
  parameter int MW         = REFL_WIDTH + 14
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       up_valid,
  output logic                       up_ready,
  input  mph_pkg::pix_ctl_t          up_ctl,
  input  logic signed [REFL_WIDTH:0] d_664_620,
  input  logic signed [REFL_WIDTH:0] d_681_620,
  input  logic signed [REFL_WIDTH:0] d_681_664,
  input  logic signed [REFL_WIDTH:0] d_709_664,
  input  logic signed [REFL_WIDTH:0] d_885_664,
  input  logic signed [REFL_WIDTH:0] d_peak_664,
  input  logic signed [REFL_WIDTH:0] s_885_664,
  output logic                       dn_valid,
  input  logic                       dn_ready,
  output mph_pkg::pix_ctl_t          ctl,
  output logic signed [MW-1:0]       sipf,
  output logic signed [MW-1:0]       sicf,
  output logic signed [MW-1:0]       bair,
  output logic signed [MW-1:0]       mph,
  output logic signed [MW-1:0]       ndvi_num,
  output logic signed [MW-1:0]       ndvi_den
);

  localparam logic signed [MW-1:0] K_SIPF_A = MW'(mph_pkg::SIPF_A);
  localparam logic signed [MW-1:0] K_SIPF_B = MW'(mph_pkg::SIPF_B);
  localparam logic signed [MW-1:0] K_SICF_A = MW'(mph_pkg::SICF_A);
  localparam logic signed [MW-1:0] K_SICF_B = MW'(mph_pkg::SICF_B);
  localparam logic signed [MW-1:0] K_BASE   = MW'(mph_pkg::BASE_SPAN);
  localparam logic signed [MW-1:0] K_BAIR_B = MW'(mph_pkg::BAIR_B);
  localparam logic signed [MW-1:0] K_NDVI   = MW'(mph_pkg::NDVI_SCALE);

  logic                   valid_r;
  mph_pkg::pix_ctl_t      ctl_r;
  logic signed [MW-1:0]   sipf_r, sicf_r, bair_r, mph_r, num_r, den_r;
  logic signed [MW-1:0]   span;
  logic signed [MW-1:0]   x0, x1, x2, x3, x4, x5, x6;

  assign up_ready = !valid_r || dn_ready;

  // sign extend the differences
  assign x0 = MW'(d_664_620);
  assign x1 = MW'(d_681_620);
  assign x2 = MW'(d_681_664);
  assign x3 = MW'(d_709_664);
  assign x4 = MW'(d_885_664);
  assign x5 = MW'(d_peak_664);
  assign x6 = MW'(s_885_664);

  // spacing from 664 nm to the peak band
  always_comb begin
    case (up_ctl.peak)
      mph_pkg::PEAK_681: span = MW'(mph_pkg::SPAN_681);
      mph_pkg::PEAK_709: span = MW'(mph_pkg::SPAN_709);
      mph_pkg::PEAK_753: span = MW'(mph_pkg::SPAN_753);
      default:           span = MW'(mph_pkg::SPAN_753);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  // scaled line heights
  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      ctl_r  <= up_ctl;
      sipf_r <= K_SIPF_A * x0 - K_SIPF_B * x1;
      sicf_r <= K_SICF_A * x2 - K_SICF_B * x3;
      bair_r <= K_BASE * x3 - K_BAIR_B * x4;
      mph_r  <= K_BASE * x5 - span * x4;
      num_r  <= K_NDVI * x4;
      den_r  <= x6;
    end
  end

  assign dn_valid = valid_r;
  assign ctl      = ctl_r;
  assign sipf     = sipf_r;
  assign sicf     = sicf_r;
  assign bair     = bair_r;
  assign mph      = mph_r;
  assign ndvi_num = num_r;
  assign ndvi_den = den_r;

endmodule

@@ rtl/mph_decide.sv @@
`timescale 1ns / 1ps

// stage 3: threshold tests and flag register
module mph_decide #(
  parameter int MW = 30
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  mph_pkg::pix_ctl_t    up_ctl,
  input  logic signed [MW-1:0] sipf,
  input  logic signed [MW-1:0] sicf,
  input  logic signed [MW-1:0] bair,
  input  logic signed [MW-1:0] mph,
  input  logic signed [MW-1:0] ndvi_num,
  input  logic signed [MW-1:0] ndvi_den,
  input  mph_pkg::cfg_regs_t   cfg,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output mph_pkg::flags_t      flags
);

  localparam logic signed [MW-1:0] K_BASE = MW'(mph_pkg::BASE_SPAN);

  logic                 valid_r;
  mph_pkg::flags_t      flags_r, flags_nxt;
  logic signed [MW-1:0] thr_s, bmin_s, fmin_s;
  logic                 ndvi_hi, sign_ok;

  assign up_ready = !valid_r || dn_ready;

  // thresholds on the 221x scale of the line heights
  assign thr_s  = K_BASE * MW'(cfg.float_mph_threshold);
  assign bmin_s = K_BASE * MW'(cfg.bair_minimum);
  assign fmin_s = K_BASE * MW'(cfg.float_mph_minimum);

  always_comb begin
    sign_ok = (sicf < 0) && (sipf > 0);
    if (ndvi_den > 0) begin
      ndvi_hi = ndvi_num >= ndvi_den;
    end else if (ndvi_den < 0) begin
      ndvi_hi = ndvi_num <= ndvi_den;
    end else begin
      ndvi_hi = 1'b0;
    end
    flags_nxt = '0;
    if (up_ctl.bad) begin
      flags_nxt.bad_input = 1'b1;
    end else if (up_ctl.peak != mph_pkg::PEAK_753) begin
      flags_nxt.cyano    = sign_ok && (bair > bmin_s);
      flags_nxt.floating = sign_ok && (bair > bmin_s) && (mph > thr_s);
    end else begin
      flags_nxt.floating  = (mph >= fmin_s) || ndvi_hi;
      flags_nxt.cyano     = flags_nxt.floating && sign_ok;
      flags_nxt.adjacency = !flags_nxt.floating;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      flags_r <= flags_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign flags    = flags_r;

endmodule

@@ rtl/mph_bloom_flag_classifier_core.sv @@
// throughput: one pixel per cycle while the result channel is not stalled
// three register stages (prep, lines, decide) lie between input and result valid
// stalls back up stage by stage; a stage with no item still takes one
// reset: synchronous active-low rst_n clears the stage valid bits and loads
// the threshold registers with their default values
`timescale 1ns / 1ps

module mph_bloom_flag_classifier_core #(
  parameter int REFL_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  mph_in_if.sink             in_ch,
  mph_out_if.source          out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int MW = REFL_WIDTH + 14;

  mph_pkg::cfg_regs_t    cfg_r;
  mph_pkg::reg_idx_t     reg_idx;
  logic                  cfg_wr;

  logic                  a_valid, b_ready, b_valid, c_ready, c_valid;
  mph_pkg::pix_ctl_t     a_ctl, b_ctl;
  mph_pkg::flags_t       c_flags;
  logic signed [REFL_WIDTH:0] d_664_620, d_681_620, d_681_664, d_709_664;
  logic signed [REFL_WIDTH:0] d_885_664, d_peak_664, s_885_664;
  logic signed [MW-1:0]  sipf, sicf, bair, mph, ndvi_num, ndvi_den;

  // configuration registers
  assign pready  = 1'b1;
  assign reg_idx = mph_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.float_mph_threshold <= mph_pkg::FLOAT_MPH_THRESHOLD_RST;
      cfg_r.bair_minimum        <= mph_pkg::BAIR_MINIMUM_RST;
      cfg_r.float_mph_minimum   <= mph_pkg::FLOAT_MPH_MINIMUM_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        mph_pkg::REG_FLOAT_MPH_THRESHOLD: cfg_r.float_mph_threshold <= pwdata[15:0];
        mph_pkg::REG_BAIR_MINIMUM:        cfg_r.bair_minimum        <= pwdata[15:0];
        mph_pkg::REG_FLOAT_MPH_MINIMUM:   cfg_r.float_mph_minimum   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (reg_idx)
      mph_pkg::REG_FLOAT_MPH_THRESHOLD: prdata = {16'h0000, cfg_r.float_mph_threshold};
      mph_pkg::REG_BAIR_MINIMUM:        prdata = {16'h0000, cfg_r.bair_minimum};
      mph_pkg::REG_FLOAT_MPH_MINIMUM:   prdata = {16'h0000, cfg_r.float_mph_minimum};
      default:                          prdata = '0;
    endcase
  end

  mph_prep #(.REFL_WIDTH(REFL_WIDTH)) u_prep (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (in_ch.valid),
    .up_ready   (in_ch.ready),
    .r620       (in_ch.refl_620),
    .r664       (in_ch.refl_664),
    .r681       (in_ch.refl_681),
    .r709       (in_ch.refl_709),
    .r753       (in_ch.refl_753),
    .r885       (in_ch.refl_885),
    .is_land    (in_ch.is_land),
    .nav_failed (in_ch.nav_failed),
    .dn_valid   (a_valid),
    .dn_ready   (b_ready),
    .ctl        (a_ctl),
    .d_664_620  (d_664_620),
    .d_681_620  (d_681_620),
    .d_681_664  (d_681_664),
    .d_709_664  (d_709_664),
    .d_885_664  (d_885_664),
    .d_peak_664 (d_peak_664),
    .s_885_664  (s_885_664)
  );

  mph_lines #(.REFL_WIDTH(REFL_WIDTH), .MW(MW)) u_lines (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (a_valid),
    .up_ready   (b_ready),
    .up_ctl     (a_ctl),
    .d_664_620  (d_664_620),
    .d_681_620  (d_681_620),
    .d_681_664  (d_681_664),
    .d_709_664  (d_709_664),
    .d_885_664  (d_885_664),
    .d_peak_664 (d_peak_664),
    .s_885_664  (s_885_664),
    .dn_valid   (b_valid),
    .dn_ready   (c_ready),
    .ctl        (b_ctl),
    .sipf       (sipf),
    .sicf       (sicf),
    .bair       (bair),
    .mph        (mph),
    .ndvi_num   (ndvi_num),
    .ndvi_den   (ndvi_den)
  );

  mph_decide #(.MW(MW)) u_decide (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (b_valid),
    .up_ready (c_ready),
    .up_ctl   (b_ctl),
    .sipf     (sipf),
    .sicf     (sicf),
    .bair     (bair),
    .mph      (mph),
    .ndvi_num (ndvi_num),
    .ndvi_den (ndvi_den),
    .cfg      (cfg_r),
    .dn_valid (c_valid),
    .dn_ready (out_ch.ready),
    .flags    (c_flags)
  );

  // result channel
  assign out_ch.valid     = c_valid;
  assign out_ch.bad_input = c_flags.bad_input;
  assign out_ch.cyano     = c_flags.cyano;
  assign out_ch.floating  = c_flags.floating;
  assign out_ch.adjacency = c_flags.adjacency;

  // a bad pixel carries no other flag
  a_bad_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.bad_input |->
      !out_ch.cyano && !out_ch.floating && !out_ch.adjacency)
    else $error("bad pixel with other flags set");

  // adjacency excludes cyano and floating
  a_adj_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.adjacency |-> !out_ch.cyano && !out_ch.floating)
    else $error("adjacency flagged with cyano or floating");

  // a land pixel reaches the output as bad when the result channel keeps ready high
  a_land_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && in_ch.is_land ##1 out_ch.ready ##1 out_ch.ready
      |=> out_ch.valid && out_ch.bad_input)
    else $error("land pixel not reported as bad input");

endmodule

@@ tb/sv/mph_bloom_flag_classifier_core_test.sv @@
`timescale 1ns / 1ps

module mph_bloom_flag_classifier_core_test;

  localparam int REFL_W     = 16;
  localparam int CLK_PERIOD = 10;
  localparam int PIPE_DEPTH = 3;

  // band centers in nm, the line heights scale with their spacing
  localparam int NM_619 = 619;
  localparam int NM_664 = 664;
  localparam int NM_681 = 681;
  localparam int NM_709 = 709;
  localparam int NM_753 = 753;
  localparam int NM_885 = 885;
  // ndvi >= 0.2 means 5*num >= den
  localparam int NDVI_INV = 5;

  localparam logic [REFL_W-1:0] REFL_MIN = {1'b1, {(REFL_W-1){1'b0}}};
  localparam logic [REFL_W-1:0] REFL_MAX = {1'b0, {(REFL_W-1){1'b1}}};

  typedef struct {
    logic signed [REFL_W-1:0] r620;
    logic signed [REFL_W-1:0] r664;
    logic signed [REFL_W-1:0] r681;
    logic signed [REFL_W-1:0] r709;
    logic signed [REFL_W-1:0] r753;
    logic signed [REFL_W-1:0] r885;
    logic                     is_land;
    logic                     nav_failed;
  } pixel_t;

  typedef struct packed {
    logic bad_input;
    logic cyano;
    logic floating;
    logic adjacency;
  } bloom_flags_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  mph_in_if #(.REFL_WIDTH(REFL_W)) in_ch ();
  mph_out_if out_ch ();

  mph_bloom_flag_classifier_core #(.REFL_WIDTH(REFL_W)) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow copy of the threshold registers
  logic signed [15:0] mph_thresh_q;
  logic signed [15:0] bair_min_q;
  logic signed [15:0] mph_floor_q;

  bloom_flags_t pending_flags[$];
  int           flag_errors;
  bit           src_idle_en;
  bit           sink_idle_en;
  int           hold_off_req;

  always #(CLK_PERIOD / 2) clk = ~clk;

  // expected flags for one pixel under the current thresholds
  function automatic bloom_flags_t classify_pixel(pixel_t p);
    longint r620, r664, r681, r709, r753, r885;
    longint span, peak_refl, peak_nm, sipf, sicf, bair, mph, num, den;
    logic at_753;
    logic ndvi_hi;
    bloom_flags_t res;
    res = '0;
    r620 = p.r620;
    r664 = p.r664;
    r681 = p.r681;
    r709 = p.r709;
    r753 = p.r753;
    r885 = p.r885;
    span = NM_885 - NM_664;
    if (r620 <= 0 || r664 <= 0 || r681 <= 0 || r709 <= 0 || p.is_land || p.nav_failed) begin
      res.bad_input = 1'b1;
      return res;
    end
    // peak search, ties go to the longer band
    if (r681 > r709) begin
      peak_nm   = NM_681;
      peak_refl = r681;
    end else begin
      peak_nm   = NM_709;
      peak_refl = r709;
    end
    at_753 = !(peak_refl > r753);
    if (at_753) begin
      peak_nm   = NM_753;
      peak_refl = r753;
    end
    // line heights scaled by their baseline spans
    sipf = (NM_681 - NM_619) * (r664 - r620) - (NM_664 - NM_619) * (r681 - r620);
    sicf = (NM_709 - NM_664) * (r681 - r664) - (NM_681 - NM_664) * (r709 - r664);
    bair = span * (r709 - r664) - (NM_709 - NM_664) * (r885 - r664);
    mph  = span * (peak_refl - r664) - (peak_nm - NM_664) * (r885 - r664);
    if (!at_753) begin
      if (sicf < 0 && sipf > 0 && bair > span * bair_min_q) begin
        res.cyano    = 1'b1;
        res.floating = mph > span * mph_thresh_q;
      end
    end else begin
      num = r885 - r664;
      den = r885 + r664;
      // negative denominator flips the compare
      if (den > 0)
        ndvi_hi = NDVI_INV * num >= den;
      else if (den < 0)
        ndvi_hi = NDVI_INV * num <= den;
      else
        ndvi_hi = 1'b0;
      if (mph >= span * mph_floor_q || ndvi_hi) begin
        res.floating = 1'b1;
        res.cyano    = sicf < 0 && sipf > 0;
      end else begin
        res.adjacency = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic pixel_t make_pixel(int b620, int b664, int b681, int b709, int b753,
                                        int b885, bit land, bit nav);
    pixel_t p;
    p.r620       = REFL_W'(b620);
    p.r664       = REFL_W'(b664);
    p.r681       = REFL_W'(b681);
    p.r709       = REFL_W'(b709);
    p.r753       = REFL_W'(b753);
    p.r885       = REFL_W'(b885);
    p.is_land    = land;
    p.nav_failed = nav;
    return p;
  endfunction

  function automatic logic [REFL_W-1:0] corner_refl();
    case ($urandom_range(0, 5))
      0: return REFL_MIN;
      1: return REFL_MAX;
      2: return '0;
      3: return '1;
      4: return REFL_W'(1);
      default: return REFL_W'($urandom());
    endcase
  endfunction

  // band values near a common level, plus some noise and corner pixels
  function automatic pixel_t random_pixel();
    pixel_t p;
    int kind;
    int base;
    int spread;
    kind = $urandom_range(0, 19);
    if (kind < 3) begin
      p = make_pixel($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                     $urandom_range(0, 1), $urandom_range(0, 1));
    end else if (kind < 6) begin
      p.r620       = corner_refl();
      p.r664       = corner_refl();
      p.r681       = corner_refl();
      p.r709       = corner_refl();
      p.r753       = corner_refl();
      p.r885       = corner_refl();
      p.is_land    = $urandom_range(0, 3) == 0;
      p.nav_failed = $urandom_range(0, 3) == 0;
    end else begin
      base   = $urandom_range(200, 12000);
      spread = $urandom_range(1, 2000);
      p = make_pixel(base + $urandom_range(0, 2 * spread) - spread,
                     base + $urandom_range(0, 2 * spread) - spread,
                     base + $urandom_range(0, 2 * spread) - spread,
                     base + $urandom_range(0, 2 * spread) - spread,
                     base + $urandom_range(0, 4 * spread) - 2 * spread,
                     base + $urandom_range(0, 8 * spread) - 4 * spread,
                     $urandom_range(0, 15) == 0, $urandom_range(0, 15) == 0);
    end
    return p;
  endfunction

  function automatic logic [15:0] random_threshold();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2, 3: return 16'($urandom());
      default: return 16'($urandom_range(0, 2000) - 500);
    endcase
  endfunction

  task automatic check_flag(string name, logic want, logic got);
    if (want !== got) begin
      $error("%s: expected %0b, got %0b", name, want, got);
      flag_errors++;
    end
  endtask

  // one pixel transfer, with an optional idle burst ahead of it
  task automatic send_pixel(pixel_t p);
    int gap;
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      repeat (gap) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_ch.valid      <= 1'b1;
    in_ch.refl_620   <= p.r620;
    in_ch.refl_664   <= p.r664;
    in_ch.refl_681   <= p.r681;
    in_ch.refl_709   <= p.r709;
    in_ch.refl_753   <= p.r753;
    in_ch.refl_885   <= p.r885;
    in_ch.is_land    <= p.is_land;
    in_ch.nav_failed <= p.nav_failed;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_flags.push_back(classify_pixel(p));
  endtask

  task automatic run_random_pixels(int count);
    repeat (count) send_pixel(random_pixel());
  endtask

  // stop offering pixels and wait until every result is back
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_flags.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  // apb write: setup then access, register takes the value at the access edge
  task automatic write_reg(mph_pkg::reg_idx_t idx, logic [15:0] value);
    logic [31:0] word;
    word = {16'($urandom()), value};
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      mph_pkg::REG_FLOAT_MPH_THRESHOLD: mph_thresh_q = word[15:0];
      mph_pkg::REG_BAIR_MINIMUM:        bair_min_q   = word[15:0];
      mph_pkg::REG_FLOAT_MPH_MINIMUM:   mph_floor_q  = word[15:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apply_thresholds(logic [15:0] thresh, logic [15:0] bair_min,
                                  logic [15:0] floor_val);
    drain_results();
    write_reg(mph_pkg::REG_FLOAT_MPH_THRESHOLD, thresh);
    write_reg(mph_pkg::REG_BAIR_MINIMUM, bair_min);
    write_reg(mph_pkg::REG_FLOAT_MPH_MINIMUM, floor_val);
  endtask

  // corners and each decision path under the reset thresholds
  task automatic test_directed_pixels();
    send_pixel(make_pixel(32767, 32767, 32767, 32767, 32767, 32767, 0, 0));
    send_pixel(make_pixel(-32768, -32768, -32768, -32768, -32768, -32768, 0, 0));
    send_pixel(make_pixel(0, 1000, 1000, 1000, 1000, 1000, 0, 0));
    send_pixel(make_pixel(1000, 0, 1000, 1000, 1000, 1000, 0, 0));
    send_pixel(make_pixel(1000, 1000, -1, 1000, 1000, 1000, 0, 0));
    send_pixel(make_pixel(1000, 1000, 1000, 0, 1000, 1000, 0, 0));
    send_pixel(make_pixel(1000, 1500, 1600, 4000, 1000, 800, 1, 0));
    send_pixel(make_pixel(1000, 1500, 1600, 4000, 1000, 800, 0, 1));
    send_pixel(make_pixel(1000, 1500, 1600, 4000, 1000, 800, 1, 1));
    // peak at 709, cyano with and without high chlorophyll
    send_pixel(make_pixel(1000, 1500, 1600, 4000, 1000, 800, 0, 0));
    send_pixel(make_pixel(1000, 1500, 1600, 2000, 1000, 800, 0, 0));
    // peak at 681, mph just under the threshold
    send_pixel(make_pixel(1000, 3000, 1500, 1000, 500, -32768, 0, 0));
    send_pixel(make_pixel(1000, 1000, 2000, 1500, 1200, 900, 0, 0));
    // equal 681 and 709 picks 709
    send_pixel(make_pixel(1000, 1200, 1500, 1500, 1000, 900, 0, 0));
    // peak at 753: adjacency, floating by mph, floating with cyano
    send_pixel(make_pixel(1000, 1000, 1000, 1000, 1100, 1000, 0, 0));
    send_pixel(make_pixel(1000, 1000, 1000, 1000, 3000, 1000, 0, 0));
    send_pixel(make_pixel(1000, 1500, 1600, 2000, 4000, 800, 0, 0));
    // mph right at and one below the floating minimum
    send_pixel(make_pixel(1000, 1000, 1000, 1000, 1328, 1000, 0, 0));
    send_pixel(make_pixel(1000, 1000, 1000, 1000, 1327, 1000, 0, 0));
    // ndvi high, ndvi with negative denominator, ndvi on the 0.2 edge
    send_pixel(make_pixel(1000, 1000, 1000, 1000, 1000, 3000, 0, 0));
    send_pixel(make_pixel(1000, 1000, 1000, 1000, 1000, -32768, 0, 0));
    send_pixel(make_pixel(1000, 1000, 1000, 1000, 1000, 1500, 0, 0));
    send_pixel(make_pixel(1000, 1000, 1000, 1000, 1000, 1499, 0, 0));
    send_pixel(make_pixel(1, 1, 1, 1, -32768, 32767, 0, 0));
  endtask

  // register extremes, and a write to the unused slot
  task automatic test_threshold_extremes();
    apply_thresholds(16'h8000, 16'h8000, 16'h8000);
    run_random_pixels(60);
    apply_thresholds(16'h7fff, 16'h7fff, 16'h7fff);
    run_random_pixels(60);
    apply_thresholds(16'h7fff, 16'h8000, 16'h0000);
    run_random_pixels(60);
    apply_thresholds(16'h0000, 16'h7fff, 16'h8000);
    run_random_pixels(60);
    apply_thresholds(16'h8000, 16'h0000, 16'h7fff);
    run_random_pixels(60);
    drain_results();
    write_reg(mph_pkg::REG_UNUSED, 16'($urandom()));
    run_random_pixels(60);
  endtask

  // long result hold-off while pixels keep coming, then a full pause
  task automatic test_stall_fill();
    drain_results();
    @(posedge clk);
    hold_off_req = 400;
    run_random_pixels(40);
    drain_results();
    run_random_pixels(20);
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 7; phase++) begin
      apply_thresholds(random_threshold(), random_threshold(), random_threshold());
      src_idle_en  = $urandom_range(0, 3) != 0;
      sink_idle_en = $urandom_range(0, 3) != 0;
      run_random_pixels(150);
    end
    // closing stretch at full rate
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    run_random_pixels(250);
  endtask

  // result sink: random stall bursts and requested long hold-offs
  initial begin : result_sink
    int burst_left;
    int hold_left;
    burst_left   = 0;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req > 0) begin
        hold_left    = hold_off_req;
        hold_off_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (burst_left > 0) begin
        burst_left--;
        out_ch.ready <= 1'b0;
      end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
        burst_left = $urandom_range(1, 18) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin : flag_check
    bloom_flags_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_flags.size() == 0) begin
        $error("result transfer with no pixel outstanding");
        flag_errors++;
      end else begin
        want = pending_flags.pop_front();
        check_flag("bad_input", want.bad_input, out_ch.bad_input);
        check_flag("cyano", want.cyano, out_ch.cyano);
        check_flag("floating", want.floating, out_ch.floating);
        check_flag("adjacency", want.adjacency, out_ch.adjacency);
      end
    end
  end

  initial begin : watchdog
    #(5_000_000);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : main_seq
    rst_n            = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_ch.valid      = 1'b0;
    in_ch.refl_620   = '0;
    in_ch.refl_664   = '0;
    in_ch.refl_681   = '0;
    in_ch.refl_709   = '0;
    in_ch.refl_753   = '0;
    in_ch.refl_885   = '0;
    in_ch.is_land    = 1'b0;
    in_ch.nav_failed = 1'b0;
    flag_errors      = 0;
    hold_off_req     = 0;
    src_idle_en      = 1'b1;
    sink_idle_en     = 1'b1;
    // reset values of the threshold registers
    mph_thresh_q     = 16'sd1258;
    bair_min_q       = 16'sd33;
    mph_floor_q      = 16'sd328;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_pixels();
    test_threshold_extremes();
    test_stall_fill();
    test_random_traffic();

    drain_results();
    repeat (10) @(posedge clk);
    if (flag_errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
